// ===== src/twc_pkg.sv =====
package twc_pkg;

  // Limits of the configuration and of the arithmetic.
  localparam int unsigned MAX_ROWS     = 64;
  localparam int unsigned MAX_TEX_LOG2 = 8;
  localparam int unsigned MAX_TEX_W    = 256;

  // Field widths.
  localparam int unsigned COL_W   = 12;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned CAM_W   = 16;
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned TEXEL_W = 16;

  // Configuration register widths and port shape.
  localparam int unsigned WH_W       = 7;
  localparam int unsigned TW_W       = 9;
  localparam int unsigned THL_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Internal arithmetic widths.
  localparam int unsigned FRAC_W    = 22;  // fractional bits of the hit coordinate
  localparam int unsigned TX_W      = 8;   // texture column
  localparam int unsigned TY_W      = 8;   // texture row
  localparam int unsigned LH_W      = 15;  // projected line height
  localparam int unsigned OFFS_W    = LH_W - 1;
  localparam int unsigned POS_W     = 24;  // only bits below 24 reach the texture row
  localparam int unsigned DIV_NUM_W = 25;
  localparam int unsigned DIV_DEN_W = 16;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_HEIGHT   = 2'd0,
    CFG_TEX_WIDTH       = 2'd1,
    CFG_TEX_HEIGHT_LOG2 = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TEX_EAST  = 2'd0,
    TEX_NORTH = 2'd1,
    TEX_WEST  = 2'd2,
    TEX_SOUTH = 2'd3
  } tex_sel_e;

  // Configuration after clamping to the supported ranges.
  typedef struct packed {
    logic [WH_W-1:0]  wh;
    logic [TW_W-1:0]  w;
    logic [THL_W-1:0] hl;
  } cfg_t;

  // One column as handed from the front to the back.
  typedef struct packed {
    logic [COL_W-1:0] column;
    tex_sel_e         tsel;
    logic [TX_W-1:0]  tx;
    logic [ROW_W-1:0] start;
    logic [ROW_W-1:0] stop;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] step;
  } desc_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== src/twc_in_if.sv =====
interface twc_in_if import twc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [COL_W-1:0]         column;
  logic [DIST_W-1:0]        perp_distance;
  logic signed [DIR_W-1:0]  dir_x;
  logic signed [DIR_W-1:0]  dir_y;
  logic [CAM_W-1:0]         cam_x;
  logic [CAM_W-1:0]         cam_y;
  logic                     wall_side;

  modport source (
    output valid, column, perp_distance, dir_x, dir_y, cam_x, cam_y, wall_side,
    input  ready
  );

  modport sink (
    input  valid, column, perp_distance, dir_x, dir_y, cam_x, cam_y, wall_side,
    output ready
  );
endinterface

// ===== src/twc_out_if.sv =====
interface twc_out_if import twc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   out_column;
  logic [ROW_W-1:0]   draw_row;
  logic [1:0]         texture_select;
  logic [TEXEL_W-1:0] texel_index;
  logic               last_row;

  modport source (
    output valid, out_column, draw_row, texture_select, texel_index, last_row,
    input  ready
  );

  modport sink (
    input  valid, out_column, draw_row, texture_select, texel_index, last_row,
    output ready
  );
endinterface

// ===== src/twc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module twc_div import twc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;

  always_comb begin
    trial = {rem_q, num_q[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    if (trial >= {1'b0, den_q}) begin
      rem_d = diff[DIV_DEN_W-1:0];
      num_d = {num_q[DIV_NUM_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DIV_DEN_W-1:0];
      num_d = {num_q[DIV_NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

`ifndef SYNTH
  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== src/twc_front.sv =====
// Front: takes one ray, works out the span, texture, texture column, step
// and starting position, and queues a column descriptor unless the span is empty.
module twc_front import twc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  twc_in_if.sink        in_i,
  output div_req_t      div_req_o,
  input  div_rsp_t      div_rsp_i,
  output logic          push_o,
  output desc_t         push_data_o,
  input  logic          full_i
);

  typedef enum logic [3:0] {
    F_IDLE,
    F_PROD,
    F_FRAC,
    F_TX,
    F_MIRROR,
    F_WAIT_LH,
    F_SPAN,
    F_WAIT_STP,
    F_POS,
    F_PUSH
  } front_state_e;

  front_state_e        state_q;
  logic [COL_W-1:0]    col_q;
  logic [DIST_W-1:0]   dist_q;
  logic [DIR_W-1:0]    dir_q;
  logic [7:0]          cam_q;
  tex_sel_e            tsel_q;
  logic                mirror_q;
  logic [FRAC_W-1:0]   prod_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [29:0]         txp_q;
  logic [TX_W-1:0]     tx_q;
  logic [LH_W-1:0]     lh_q;
  logic [ROW_W-1:0]    start_q;
  logic [ROW_W-1:0]    stop_q;
  logic                empty_q;
  logic [OFFS_W-1:0]   offs_q;
  logic [POS_W-1:0]    stp_q;
  logic [POS_W-1:0]    pos_q;

  logic                accept;
  logic                side;
  logic [FRAC_W-1:0]   dir_ext;
  logic [FRAC_W-1:0]   hit_prod;
  logic [FRAC_W+TW_W-1:0] tx_prod;
  logic [TW_W-1:0]     tx_mirror;
  logic [OFFS_W+POS_W-1:0] pos_prod;
  logic [ROW_W-1:0]    half_wh;
  logic [OFFS_W-1:0]   lh_half;
  logic [LH_W-1:0]     end_raw;
  logic [WH_W-1:0]     wh_m1;
  logic [ROW_W-1:0]    start_c;
  logic [ROW_W-1:0]    stop_c;
  logic [OFFS_W-1:0]   offs_c;
  logic                empty_c;

  assign accept = in_i.valid && in_i.ready;
  assign side   = in_i.wall_side;

  // The direction is signed, so it is sign-extended before the product is
  // cut to the fractional bits of the hit coordinate.
  assign dir_ext   = {{(FRAC_W-DIR_W){dir_q[DIR_W-1]}}, dir_q};
  assign hit_prod  = FRAC_W'(dist_q) * dir_ext;
  assign tx_prod   = frac_q * cfg_i.w;
  assign tx_mirror = cfg_i.w - {1'b0, txp_q[29:22]} - TW_W'(1);
  assign pos_prod  = offs_q * stp_q;

  // Span clipping against the window.
  always_comb begin
    half_wh = cfg_i.wh[WH_W-1:1];
    lh_half = lh_q[LH_W-1:1];
    end_raw = LH_W'(lh_half) + LH_W'(half_wh);
    wh_m1   = cfg_i.wh - WH_W'(1);
    if (OFFS_W'(half_wh) > lh_half) begin
      start_c = half_wh - lh_half[ROW_W-1:0];
      offs_c  = '0;
    end else begin
      start_c = '0;
      offs_c  = lh_half - OFFS_W'(half_wh);
    end
    if (end_raw >= LH_W'(cfg_i.wh)) begin
      stop_c = wh_m1[ROW_W-1:0];
    end else begin
      stop_c = end_raw[ROW_W-1:0];
    end
    empty_c = (cfg_i.wh == '0) || (start_c >= stop_c);
  end

  always_comb begin
    div_req_o.start = (state_q == F_PROD) || (state_q == F_SPAN);
    if (state_q == F_SPAN) begin
      div_req_o.num = DIV_NUM_W'(1) << (5'(cfg_i.hl) + 5'd16);
      div_req_o.den = DIV_DEN_W'(lh_q);
    end else begin
      div_req_o.num = DIV_NUM_W'({cfg_i.wh, 8'h00});
      div_req_o.den = dist_q;
    end
  end

  assign in_i.ready = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !empty_q && !full_i;

  assign push_data_o.column = col_q;
  assign push_data_o.tsel   = tsel_q;
  assign push_data_o.tx     = tx_q;
  assign push_data_o.start  = start_q;
  assign push_data_o.stop   = stop_q;
  assign push_data_o.pos    = pos_q;
  assign push_data_o.step   = stp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      col_q    <= '0;
      dist_q   <= '0;
      dir_q    <= '0;
      cam_q    <= '0;
      tsel_q   <= TEX_EAST;
      mirror_q <= 1'b0;
      prod_q   <= '0;
      frac_q   <= '0;
      txp_q    <= '0;
      tx_q     <= '0;
      lh_q     <= '0;
      start_q  <= '0;
      stop_q   <= '0;
      empty_q  <= 1'b1;
      offs_q   <= '0;
      stp_q    <= '0;
      pos_q    <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            col_q  <= in_i.column;
            dist_q <= (in_i.perp_distance == '0) ? DIST_W'(1) : in_i.perp_distance;
            if (!side) begin
              dir_q    <= in_i.dir_y;
              cam_q    <= in_i.cam_y[7:0];
              tsel_q   <= in_i.dir_x[DIR_W-1] ? TEX_WEST : TEX_EAST;
              mirror_q <= !in_i.dir_x[DIR_W-1] && (in_i.dir_x != '0);
            end else begin
              dir_q    <= in_i.dir_x;
              cam_q    <= in_i.cam_x[7:0];
              tsel_q   <= (in_i.dir_y[DIR_W-1] || (in_i.dir_y == '0)) ? TEX_NORTH
                                                                        : TEX_SOUTH;
              mirror_q <= in_i.dir_y[DIR_W-1];
            end
            state_q <= F_PROD;
          end
        end
        F_PROD: begin
          prod_q  <= hit_prod;
          state_q <= F_FRAC;
        end
        F_FRAC: begin
          frac_q  <= {cam_q, 14'h0000} + prod_q;
          state_q <= F_TX;
        end
        F_TX: begin
          txp_q   <= tx_prod[29:0];
          state_q <= F_MIRROR;
        end
        F_MIRROR: begin
          tx_q    <= mirror_q ? tx_mirror[TX_W-1:0] : txp_q[29:22];
          state_q <= F_WAIT_LH;
        end
        F_WAIT_LH: begin
          if (div_rsp_i.done) begin
            lh_q    <= div_rsp_i.quot[LH_W-1:0];
            state_q <= F_SPAN;
          end
        end
        F_SPAN: begin
          start_q <= start_c;
          stop_q  <= stop_c;
          empty_q <= empty_c;
          offs_q  <= offs_c;
          state_q <= F_WAIT_STP;
        end
        F_WAIT_STP: begin
          if (div_rsp_i.done) begin
            stp_q   <= (lh_q == '0) ? '0 : div_rsp_i.quot[POS_W-1:0];
            state_q <= F_POS;
          end
        end
        F_POS: begin
          pos_q   <= pos_prod[POS_W-1:0];
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (empty_q || !full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/twc_fifo.sv =====
// Short descriptor queue between front and back.
module twc_fifo import twc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output desc_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("descriptor queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("descriptor queue read while empty");
`endif

endmodule

// ===== src/twc_back.sv =====
// Back: walks the rows of one column, stepping the texture position,
// and drives the registered output channel.
module twc_back import twc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  desc_t    head_i,
  input  logic     empty_i,
  output logic     pop_o,
  twc_out_if.source out_o
);

  logic               active_q;
  logic [COL_W-1:0]   col_q;
  tex_sel_e           tsel_q;
  logic [TX_W-1:0]    tx_q;
  logic [ROW_W-1:0]   row_q;
  logic [ROW_W-1:0]   stop_q;
  logic [POS_W-1:0]   pos_q;
  logic [POS_W-1:0]   step_q;

  logic               oval_q;
  logic [COL_W-1:0]   ocol_q;
  logic [ROW_W-1:0]   orow_q;
  tex_sel_e           otsel_q;
  logic [TEXEL_W-1:0] otexel_q;
  logic               olast_q;

  logic               can_emit;
  logic               emit;
  logic               is_last;
  logic [TY_W-1:0]    ty_mask;
  logic [TY_W-1:0]    ty;
  logic [TY_W+TW_W-1:0] texel;
  logic [TW_W-1:0]    ty_mask_full;

  assign can_emit     = !oval_q || out_o.ready;
  assign emit         = active_q && can_emit;
  assign pop_o        = !active_q && !empty_i;
  assign is_last      = (row_q == stop_q - ROW_W'(1));
  assign ty_mask_full = (TW_W'(1) << cfg_i.hl) - TW_W'(1);
  assign ty_mask      = ty_mask_full[TY_W-1:0];
  assign ty           = pos_q[POS_W-1:16] & ty_mask;
  assign texel        = ty * cfg_i.w + (TY_W + TW_W)'(tx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
      end else if (emit && is_last) begin
        active_q <= 1'b0;
      end
      if (emit) begin
        oval_q <= 1'b1;
      end else if (out_o.ready) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      col_q  <= head_i.column;
      tsel_q <= head_i.tsel;
      tx_q   <= head_i.tx;
      row_q  <= head_i.start;
      stop_q <= head_i.stop;
      pos_q  <= head_i.pos + head_i.step;
      step_q <= head_i.step;
    end else if (emit) begin
      row_q <= row_q + ROW_W'(1);
      pos_q <= pos_q + step_q;
    end
    if (emit) begin
      ocol_q   <= col_q;
      orow_q   <= row_q;
      otsel_q  <= tsel_q;
      otexel_q <= texel[TEXEL_W-1:0];
      olast_q  <= is_last;
    end
  end

  assign out_o.valid          = oval_q;
  assign out_o.out_column     = ocol_q;
  assign out_o.draw_row       = orow_q;
  assign out_o.texture_select = otsel_q;
  assign out_o.texel_index    = otexel_q;
  assign out_o.last_row       = olast_q;

`ifndef SYNTH
  a_row_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (row_q < stop_q))
    else $error("row walk ran past the end of the span");
  a_column_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && !olast_q) |-> active_q)
    else $error("column closed before its final row was shown");
`endif

endmodule

// ===== src/textured_wall_column_generator.sv =====
// Textured wall column generator. Each input transaction is one cast ray for
// one screen column; the block answers with one output transaction per drawn
// row of that column, from the clipped span start up to but not including its
// end, each carrying the screen row, the texture chosen from wall side and
// ray direction, and the texel index (texel row times texture width plus
// texel column). A column whose span is empty produces no output at all, and
// the final row of a column is flagged with last_row. Internally a front
// section works out the per-column figures, using a shared divider that
// yields one quotient bit per cycle for the two divisions (line height and
// texture step); the front takes no new ray until it is done with the last.
// A two-entry descriptor queue then feeds a back section that delivers one
// row per cycle while the output is not stalled, and loads a new column
// only once the one before is out; front and back overlap in steady flow.
// The user must write configuration through the plain register port only
// while the block holds no work; the block itself does not enforce this.
module textured_wall_column_generator import twc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  twc_in_if.sink                in_i,
  twc_out_if.source             out_o
);

  // Raw configuration registers, as written.
  logic [WH_W-1:0]  wh_q;
  logic [TW_W-1:0]  tw_q;
  logic [THL_W-1:0] thl_q;

  // Configuration clamped to the ranges the datapath supports.
  cfg_t cfg;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic  push;
  desc_t push_data;
  logic  full;
  logic  empty;
  logic  pop;
  desc_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wh_q  <= WH_W'(64);
      tw_q  <= TW_W'(64);
      thl_q <= THL_W'(6);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_HEIGHT:   wh_q  <= cfg_data_i[WH_W-1:0];
        CFG_TEX_WIDTH:       tw_q  <= cfg_data_i[TW_W-1:0];
        CFG_TEX_HEIGHT_LOG2: thl_q <= cfg_data_i[THL_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // A window taller than the supported row count acts as the maximum; a
  // texture width of zero acts as one and anything wider than the maximum is
  // cut back; an oversized height exponent is held at its ceiling.
  always_comb begin
    cfg.wh = (wh_q > WH_W'(MAX_ROWS)) ? WH_W'(MAX_ROWS) : wh_q;
    if (tw_q == '0) begin
      cfg.w = TW_W'(1);
    end else if (tw_q > TW_W'(MAX_TEX_W)) begin
      cfg.w = TW_W'(MAX_TEX_W);
    end else begin
      cfg.w = tw_q;
    end
    cfg.hl = (thl_q > THL_W'(MAX_TEX_LOG2)) ? THL_W'(MAX_TEX_LOG2) : thl_q;
  end

  // The front classifies each ray and prepares its column descriptor.
  twc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Shared serial divider for line height and texture step.
  twc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // The queue lets the front start the next ray while rows are still going out.
  twc_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  // Unless stalled, the back emits one row per cycle into a registered output stage.
  twc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
